FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the predictor top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GBP_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define GBP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/gbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 8;
  localparam int CBITS_W    = 4;
  localparam int HMODE_W    = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W      = 8;
  localparam int SIZE_W     = 4;

  localparam logic [CBITS_W-1:0] CBITS_RESET = 4'd2;
  localparam logic [CBITS_W-1:0] CBITS_MAX   = 4'd8;

  // register index, taken from paddr bit 2
  localparam logic REG_COUNTER_BITS = 1'b0;
  localparam logic REG_HASH_MODE    = 1'b1;

  localparam logic [HMODE_W-1:0] HASH_PC   = 2'd0;
  localparam logic [HMODE_W-1:0] HASH_HIST = 2'd1;
  localparam logic [HMODE_W-1:0] HASH_XOR  = 2'd2;

  typedef struct packed {
    logic actual_taken;
    logic predicted_taken;
    logic btb_hit;
    logic resolve_in_execute;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gas_branch_predictor_with_btb_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// GAs two-level branch predictor with a set-associative branch target buffer. Each input
// word is one retired instruction; one result word per instruction says whether it resolves
// at fetch or stalls until execute, plus target buffer hit, prediction and actual outcome.
// One instruction is taken per cycle while no sweep runs and the output is not stalled:
// the input register stage reads the buffer ways and the counter table, the second stage
// compares tags, picks the victim, trains the counter and writes back, with forwarding of
// the previous write so back-to-back hits on the same set or counter see fresh data, and
// an output register holds the result. After reset the block sweeps the tables over
// max(2^(HISTORY_BITS+TABLE_SET_BITS), BTB_SETS) indices (4096 by default), in_tready low;
// every counter_bits write sweeps the counter table again. BTB_SETS must be a power of two.
module gas_branch_predictor_with_btb_top #(
  parameter int BTB_SETS       = 256,
  parameter int BTB_WAYS       = 4,
  parameter int HISTORY_BITS   = 10,
  parameter int TABLE_SET_BITS = 2,
  parameter int ADDR_BITS      = 48,
  localparam int IN_W          = ((2 * ADDR_BITS + gbp_pkg::SIZE_W + 2 + 7) / 8) * 8
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // branch_address, instr_size, next_address, is_branch_op, is_conditional
  input  wire  [IN_W-1:0]                    in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // resolve_in_execute, btb_hit, predicted_taken, actual_taken
  output logic [gbp_pkg::OUT_W-1:0]          out_tdata,
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire  [gbp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire  [gbp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [gbp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int PC_W      = ADDR_BITS - 2;
  localparam int SET_BITS  = $clog2(BTB_SETS);
  localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_W     = PC_W - SET_BITS;
  localparam int STAMP_W   = gbp_pkg::STAMP_W;
  localparam int ENT_W     = TAG_W + STAMP_W;
  localparam int WAY_LVLS  = $clog2(BTB_WAYS);
  localparam int WAY_W     = (WAY_LVLS > 0) ? WAY_LVLS : 1;
  localparam int WAY_P2    = 1 << WAY_LVLS;
  localparam int CT_W      = HISTORY_BITS + TABLE_SET_BITS;
  localparam int CT_DEPTH  = 1 << CT_W;
  localparam int SET_COUNT = 1 << TABLE_SET_BITS;
  localparam int SW_N      = (CT_DEPTH > BTB_SETS) ? CT_DEPTH : BTB_SETS;
  localparam int SW_W      = $clog2(SW_N);
  localparam int CNT_W     = gbp_pkg::CNT_W;
  localparam int SIZE_LO   = ADDR_BITS;
  localparam int NEXT_LO   = ADDR_BITS + gbp_pkg::SIZE_W;
  localparam int BR_POS    = 2 * ADDR_BITS + gbp_pkg::SIZE_W;
  localparam int COND_POS  = BR_POS + 1;

  // configuration
  logic [gbp_pkg::CBITS_W-1:0] counter_bits_r;
  logic [gbp_pkg::HMODE_W-1:0] hash_mode_r;
  logic                        cfg_wr;

  // table sweep
  logic            sweep_r;
  logic            sweep_btb_r;
  logic [SW_W-1:0] sw_idx_r;

  // global state
  logic [STAMP_W-1:0]      stamp_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic [HISTORY_BITS-1:0] hist_nxt;

  // input decode
  logic [ADDR_BITS-1:0]           in_addr;
  logic [gbp_pkg::SIZE_W-1:0]     in_size;
  logic [ADDR_BITS-1:0]           in_next;
  logic [ADDR_BITS-1:0]           seq_addr;
  logic [PC_W-1:0]                in_pc;
  logic                           in_taken;
  logic [SET_W-1:0]               in_set;
  logic [TAG_W-1:0]               in_tag;
  logic [HISTORY_BITS-1:0]        in_line;
  logic [CT_W-1:0]                in_slot;
  logic                           in_fire;

  // second stage
  logic              s1_v_r;
  logic              s1_br_r;
  logic              s1_cond_r;
  logic              s1_taken_r;
  logic [SET_W-1:0]  s1_set_r;
  logic [TAG_W-1:0]  s1_tag_r;
  logic [CT_W-1:0]   s1_slot_r;
  logic              s1_adv;
  logic              s1_commit;

  // target buffer
  wire  [ENT_W-1:0]   btb_rd [BTB_WAYS];
  logic [TAG_W-1:0]   way_tag [BTB_WAYS];
  logic [STAMP_W-1:0] way_stamp [BTB_WAYS];
  logic [BTB_WAYS-1:0] hit_vec;
  logic               hit;
  logic [WAY_W-1:0]   hit_way;
  logic [WAY_W-1:0]   victim;
  logic [WAY_W-1:0]   wr_way;
  logic [STAMP_W-1:0] new_stamp;
  logic               btb_we;
  logic [BTB_WAYS-1:0] btb_wmask;
  logic               btb_sweep_we;
  logic               bfwd_v_r;
  logic [SET_W-1:0]   bfwd_set_r;
  logic [WAY_W-1:0]   bfwd_way_r;
  logic [ENT_W-1:0]   bfwd_data_r;

  logic [STAMP_W-1:0] vt_stamp [WAY_P2];
  logic [WAY_W-1:0]   vt_idx [WAY_P2];
  logic               vt_ok [WAY_P2];

  // counter table
  logic [CNT_W-1:0] ct_mem [CT_DEPTH];
  logic [CNT_W-1:0] ct_rd_r;
  logic [CNT_W-1:0] ct_val;
  logic [CNT_W-1:0] ct_new;
  logic             ct_we;
  logic             ct_sweep_we;
  logic             cfwd_v_r;
  logic [CT_W-1:0]  cfwd_slot_r;
  logic [CNT_W-1:0] cfwd_data_r;
  logic [gbp_pkg::CBITS_W-1:0] eff_bits;
  logic [CNT_W:0]   cnt_span;
  logic [CNT_W-1:0] cnt_max;
  logic [CNT_W-1:0] cnt_thr;
  logic             pred_c;

  // result
  logic              out_v_r;
  gbp_pkg::result_t  out_data_r;
  gbp_pkg::result_t  res;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      gbp_pkg::REG_COUNTER_BITS:
        cfg_prdata = gbp_pkg::CFG_DATA_W'(counter_bits_r);
      gbp_pkg::REG_HASH_MODE:
        cfg_prdata = gbp_pkg::CFG_DATA_W'(hash_mode_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_bits_r <= gbp_pkg::CBITS_RESET;
      hash_mode_r    <= gbp_pkg::HASH_PC;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        gbp_pkg::REG_COUNTER_BITS: counter_bits_r <= cfg_pwdata[gbp_pkg::CBITS_W-1:0];
        gbp_pkg::REG_HASH_MODE:    hash_mode_r    <= cfg_pwdata[gbp_pkg::HMODE_W-1:0];
        default: ;
      endcase
    end
  end

  // sweep sequencer
  assign btb_sweep_we = sweep_r && sweep_btb_r &&
                        ({1'b0, sw_idx_r} < (SW_W + 1)'(BTB_SETS));
  assign ct_sweep_we  = sweep_r && ({1'b0, sw_idx_r} < (SW_W + 1)'(CT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_btb_r <= 1'b1;
      sw_idx_r    <= '0;
    end else if (cfg_wr && cfg_paddr[2] == gbp_pkg::REG_COUNTER_BITS) begin
      sweep_r  <= 1'b1;
      sw_idx_r <= '0;
    end else if (sweep_r) begin
      if (sw_idx_r == SW_W'(SW_N - 1)) begin
        sweep_r     <= 1'b0;
        sweep_btb_r <= 1'b0;
      end else begin
        sw_idx_r <= sw_idx_r + 1'b1;
      end
    end
  end

  // effective counter width and threshold
  always_comb begin
    if (counter_bits_r == '0) begin
      eff_bits = 4'd1;
    end else if (counter_bits_r > gbp_pkg::CBITS_MAX) begin
      eff_bits = gbp_pkg::CBITS_MAX;
    end else begin
      eff_bits = counter_bits_r;
    end
  end

  assign cnt_span = (CNT_W + 1)'(1) << eff_bits;
  assign cnt_max  = CNT_W'(cnt_span - 1'b1);
  assign cnt_thr  = CNT_W'(cnt_span >> 1);

  // handshake
  assign s1_adv    = !out_v_r || out_tready;
  assign s1_commit = s1_v_r && s1_adv;
  assign in_tready = !sweep_r && (!s1_v_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  // input decode
  assign in_addr  = in_tdata[ADDR_BITS-1:0];
  assign in_size  = in_tdata[SIZE_LO +: gbp_pkg::SIZE_W];
  assign in_next  = in_tdata[NEXT_LO +: ADDR_BITS];
  assign seq_addr = in_addr + ADDR_BITS'(in_size);
  assign in_taken = seq_addr != in_next;
  assign in_pc    = in_addr[ADDR_BITS-1:2];
  assign in_set   = SET_W'(in_pc & PC_W'(BTB_SETS - 1));
  assign in_tag   = TAG_W'(in_pc >> SET_BITS);

  // history as it stands once the word in the second stage has retired
  assign hist_nxt = (s1_commit && s1_br_r && s1_cond_r) ?
                    HISTORY_BITS'({hist_r, s1_taken_r}) : hist_r;

  always_comb begin
    case (hash_mode_r)
      gbp_pkg::HASH_PC:   in_line = HISTORY_BITS'(in_pc);
      gbp_pkg::HASH_HIST: in_line = hist_nxt;
      default:            in_line = HISTORY_BITS'(in_pc) ^ hist_nxt;
    endcase
  end

  assign in_slot = (CT_W'(in_line) << TABLE_SET_BITS) | CT_W'(in_pc & PC_W'(SET_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_commit) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_br_r    <= in_tdata[BR_POS];
      s1_cond_r  <= in_tdata[COND_POS];
      s1_taken_r <= in_taken;
      s1_set_r   <= in_set;
      s1_tag_r   <= in_tag;
      s1_slot_r  <= in_slot;
    end
  end

  // target buffer ways
  assign new_stamp = stamp_r + 1'b1;
  assign btb_we    = s1_commit && s1_br_r;
  assign wr_way    = hit ? hit_way : victim;

  for (genvar w = 0; w < BTB_WAYS; w++) begin : g_way
    logic [ENT_W-1:0] btb_mem [BTB_SETS];
    logic [ENT_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (btb_sweep_we) begin
        btb_mem[SET_W'(sw_idx_r)] <= '0;
      end else if (btb_wmask[w]) begin
        btb_mem[s1_set_r] <= {s1_tag_r, new_stamp};
      end
      if (in_fire) begin
        rd_r <= btb_mem[in_set];
      end
    end

    assign btb_rd[w]    = rd_r;
    assign btb_wmask[w] = btb_we && (wr_way == WAY_W'(w));
  end

  always_comb begin
    for (int w = 0; w < BTB_WAYS; w++) begin
      if (bfwd_v_r && bfwd_set_r == s1_set_r && bfwd_way_r == WAY_W'(w)) begin
        way_tag[w]   = bfwd_data_r[ENT_W-1 -: TAG_W];
        way_stamp[w] = bfwd_data_r[STAMP_W-1:0];
      end else begin
        way_tag[w]   = btb_rd[w][ENT_W-1 -: TAG_W];
        way_stamp[w] = btb_rd[w][STAMP_W-1:0];
      end
      hit_vec[w] = way_tag[w] == s1_tag_r;
    end
  end

  assign hit = |hit_vec;

  // lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = BTB_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  // victim: smallest stamp, ties to the higher way
  always_comb begin
    for (int i = 0; i < WAY_P2; i++) begin
      vt_idx[i] = WAY_W'(i);
      if (i < BTB_WAYS) begin
        vt_ok[i]    = 1'b1;
        vt_stamp[i] = way_stamp[i];
      end else begin
        vt_ok[i]    = 1'b0;
        vt_stamp[i] = '1;
      end
    end
    for (int l = 0; l < WAY_LVLS; l++) begin
      for (int i = 0; i < WAY_P2; i += (2 << l)) begin
        if (vt_ok[i + (1 << l)] &&
            (!vt_ok[i] || vt_stamp[i + (1 << l)] <= vt_stamp[i])) begin
          vt_ok[i]    = 1'b1;
          vt_stamp[i] = vt_stamp[i + (1 << l)];
          vt_idx[i]   = vt_idx[i + (1 << l)];
        end
      end
    end
    victim = vt_idx[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bfwd_v_r <= 1'b0;
    end else if (sweep_r) begin
      bfwd_v_r <= 1'b0;
    end else if (btb_we) begin
      bfwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (btb_we) begin
      bfwd_set_r  <= s1_set_r;
      bfwd_way_r  <= wr_way;
      bfwd_data_r <= {s1_tag_r, new_stamp};
    end
  end

  // counter table
  assign ct_we = s1_commit && s1_br_r && s1_cond_r;

  always_ff @(posedge clk) begin
    if (ct_sweep_we) begin
      ct_mem[CT_W'(sw_idx_r)] <= cnt_thr;
    end else if (ct_we) begin
      ct_mem[s1_slot_r] <= ct_new;
    end
    if (in_fire) begin
      ct_rd_r <= ct_mem[in_slot];
    end
  end

  assign ct_val = (cfwd_v_r && cfwd_slot_r == s1_slot_r) ? cfwd_data_r : ct_rd_r;
  assign pred_c = ct_val >= cnt_thr;

  always_comb begin
    ct_new = ct_val;
    if (s1_taken_r) begin
      if (ct_val < cnt_max) begin
        ct_new = ct_val + 1'b1;
      end
    end else if (ct_val != '0) begin
      ct_new = ct_val - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfwd_v_r <= 1'b0;
    end else if (sweep_r) begin
      cfwd_v_r <= 1'b0;
    end else if (ct_we) begin
      cfwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ct_we) begin
      cfwd_slot_r <= s1_slot_r;
      cfwd_data_r <= ct_new;
    end
  end

  // global state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
      hist_r  <= '0;
    end else begin
      hist_r <= hist_nxt;
      if (btb_we) begin
        stamp_r <= new_stamp;
      end
    end
  end

  // result
  always_comb begin
    res.actual_taken       = s1_taken_r;
    res.btb_hit            = s1_br_r && hit;
    res.predicted_taken    = s1_br_r && (s1_cond_r ? pred_c : s1_taken_r);
    res.resolve_in_execute = s1_br_r &&
                             (hit ? (s1_cond_r && (pred_c != s1_taken_r)) : s1_taken_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_commit) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = gbp_pkg::OUT_W'(out_data_r);

  `GBP_ASSERT_NEXT(a_stamp_step, clk, rst_n, btb_we, stamp_r == $past(stamp_r) + 1'b1)
  `GBP_ASSERT_NEXT(a_hist_shift, clk, rst_n, ct_we, hist_r[0] == $past(s1_taken_r))
  `GBP_ASSERT_IMP(a_one_way_written, clk, rst_n, btb_we, $onehot(btb_wmask))
  `GBP_ASSERT_NEXT(a_nonbranch_quiet, clk, rst_n, s1_commit && !s1_br_r,
    !out_data_r.btb_hit && !out_data_r.predicted_taken && !out_data_r.resolve_in_execute)

endmodule

`default_nettype wire

FILE: tb/branch_outcome_checker.sv
`timescale 1ns / 1ps

module branch_outcome_checker (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_tvalid,
  input  wire                           in_tready,
  // branch_address, instr_size, next_address, is_branch_op, is_conditional
  input  wire  [103:0]                  in_tdata,
  input  wire                           out_tvalid,
  input  wire                           out_tready,
  // resolve_in_execute, btb_hit, predicted_taken, actual_taken
  input  wire  [gbp_pkg::OUT_W-1:0]     out_tdata,
  input  wire                           cfg_psel,
  input  wire                           cfg_penable,
  input  wire                           cfg_pwrite,
  input  wire                           cfg_pready,
  input  wire  [gbp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire  [gbp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output int                            mismatches,
  output int                            outstanding
);

  localparam int SETS     = 256;
  localparam int WAYS     = 4;
  localparam int HIST_W   = 10;
  localparam int SETSEL_W = 2;
  localparam int PHT_SIZE = 1 << (HIST_W + SETSEL_W);

  logic [37:0]                  btb_tags   [SETS*WAYS];
  logic [31:0]                  btb_stamps [SETS*WAYS];
  logic [31:0]                  stamp_clock;
  logic [HIST_W-1:0]            ghist;
  logic [gbp_pkg::CNT_W-1:0]    pht [PHT_SIZE];
  logic [gbp_pkg::CBITS_W-1:0]  cbits;
  logic [gbp_pkg::HMODE_W-1:0]  hmode;
  gbp_pkg::result_t             expected_results [$];

  function automatic logic [gbp_pkg::CNT_W-1:0] counter_ceiling(
      input logic [gbp_pkg::CBITS_W-1:0] bits);
    int b;
    logic [8:0] m;
    b = bits;
    if (b < 1) b = 1;
    if (b > 8) b = 8;
    m = (9'd1 << b) - 9'd1;
    return m[7:0];
  endfunction

  function automatic logic [gbp_pkg::CNT_W-1:0] counter_midpoint(
      input logic [gbp_pkg::CBITS_W-1:0] bits);
    logic [8:0] m;
    m = ({1'b0, counter_ceiling(bits)} + 9'd1) >> 1;
    return m[7:0];
  endfunction

  task automatic predict_resolution(input logic [103:0] instr,
                                    output gbp_pkg::result_t res);
    logic [47:0]               addr;
    logic [3:0]                len;
    logic [47:0]               dest;
    logic [47:0]               seq;
    logic                      br;
    logic                      cond;
    logic                      taken;
    logic                      hit;
    logic                      pred;
    logic [45:0]               pc;
    logic [37:0]               tag;
    logic [31:0]               best;
    logic [HIST_W-1:0]         line;
    logic [11:0]               slot;
    logic [gbp_pkg::CNT_W-1:0] ceil;
    logic [gbp_pkg::CNT_W-1:0] thr;
    int                        base;
    int                        victim;
    addr  = instr[47:0];
    len   = instr[51:48];
    dest  = instr[99:52];
    br    = instr[100];
    cond  = instr[101];
    seq   = addr + {44'd0, len};
    taken = (seq != dest);
    res   = '0;
    res.actual_taken = taken;
    if (br) begin
      pc   = addr[47:2];
      tag  = pc[45:8];
      base = int'(pc[7:0]) * WAYS;
      stamp_clock = stamp_clock + 32'd1;
      hit = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
        if (!hit && btb_tags[base+i] == tag) begin
          hit = 1'b1;
          btb_stamps[base+i] = stamp_clock;
        end
      end
      if (!hit) begin
        // least recently stamped way, ties to the highest way
        best   = '1;
        victim = 0;
        for (int i = 0; i < WAYS; i++) begin
          if (btb_stamps[base+i] <= best) begin
            best   = btb_stamps[base+i];
            victim = i;
          end
        end
        btb_tags[base+victim]   = tag;
        btb_stamps[base+victim] = stamp_clock;
      end
      pred = taken;
      if (cond) begin
        ceil = counter_ceiling(cbits);
        thr  = counter_midpoint(cbits);
        case (hmode)
          gbp_pkg::HASH_PC: begin
            line = pc[HIST_W-1:0];
          end
          gbp_pkg::HASH_HIST: begin
            line = ghist;
          end
          default: begin
            line = pc[HIST_W-1:0] ^ ghist;
          end
        endcase
        slot = {line, pc[SETSEL_W-1:0]};
        pred = (pht[slot] >= thr);
        if (taken) begin
          if (pht[slot] < ceil) pht[slot] = pht[slot] + 8'd1;
        end else begin
          if (pht[slot] > 0) pht[slot] = pht[slot] - 8'd1;
        end
        ghist = {ghist[HIST_W-2:0], taken};
      end
      res.btb_hit            = hit;
      res.predicted_taken    = pred;
      res.resolve_in_execute = hit ? (cond && (pred != taken)) : taken;
    end
  endtask

  always @(posedge clk) begin
    gbp_pkg::result_t got;
    gbp_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SETS*WAYS; i++) begin
        btb_tags[i]   = '0;
        btb_stamps[i] = '0;
      end
      stamp_clock = '0;
      ghist       = '0;
      cbits       = gbp_pkg::CBITS_RESET;
      hmode       = gbp_pkg::HASH_PC;
      for (int i = 0; i < PHT_SIZE; i++) pht[i] = counter_midpoint(gbp_pkg::CBITS_RESET);
      expected_results.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == gbp_pkg::REG_COUNTER_BITS) begin
          cbits = cfg_pwdata[gbp_pkg::CBITS_W-1:0];
          for (int i = 0; i < PHT_SIZE; i++) pht[i] = counter_midpoint(cbits);
        end else begin
          hmode = cfg_pwdata[gbp_pkg::HMODE_W-1:0];
        end
      end
      if (in_tvalid && in_tready) begin
        predict_resolution(in_tdata, want);
        expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[3:0];
        if (expected_results.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (got.resolve_in_execute !== want.resolve_in_execute) begin
            $error("resolve_in_execute: expected %0b, got %0b",
                   want.resolve_in_execute, got.resolve_in_execute);
            mismatches++;
          end
          if (got.btb_hit !== want.btb_hit) begin
            $error("btb_hit: expected %0b, got %0b", want.btb_hit, got.btb_hit);
            mismatches++;
          end
          if (got.predicted_taken !== want.predicted_taken) begin
            $error("predicted_taken: expected %0b, got %0b",
                   want.predicted_taken, got.predicted_taken);
            mismatches++;
          end
          if (got.actual_taken !== want.actual_taken) begin
            $error("actual_taken: expected %0b, got %0b",
                   want.actual_taken, got.actual_taken);
            mismatches++;
          end
        end
      end
      outstanding = expected_results.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int IN_W        = 104;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOT_COUNT   = 24;
  localparam int HOLD_CYCLES = 400;
  localparam logic [47:0] ADDR_MASK = {48{1'b1}};
  // mode code 3 falls back to pc xor history
  localparam logic [gbp_pkg::HMODE_W-1:0] HASH_XOR_ALIAS = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // branch_address, instr_size, next_address, is_branch_op, is_conditional
  logic [IN_W-1:0]                 in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // resolve_in_execute, btb_hit, predicted_taken, actual_taken
  logic [gbp_pkg::OUT_W-1:0]       out_tdata;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [gbp_pkg::CFG_ADDR_W-1:0]  cfg_paddr;
  logic [gbp_pkg::CFG_DATA_W-1:0]  cfg_pwdata;
  logic [gbp_pkg::CFG_DATA_W-1:0]  cfg_prdata;
  logic                            cfg_pready;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  bit hold_req    = 1'b0;
  bit rx_steady   = 1'b0;

  logic [47:0] hot_pc   [HOT_COUNT];
  logic [3:0]  hot_len  [HOT_COUNT];
  logic [47:0] hot_dest [HOT_COUNT];
  logic        hot_cond [HOT_COUNT];
  int          hot_bias [HOT_COUNT];

  gas_branch_predictor_with_btb_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  branch_outcome_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IN_W-1:0] pack_instr(input logic [47:0] addr,
                                                 input logic [3:0] len,
                                                 input logic [47:0] dest,
                                                 input logic br,
                                                 input logic cond);
    return {2'b00, cond, br, dest, len, addr};
  endfunction

  task automatic send_instr(input logic [IN_W-1:0] word, input int gap);
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic reg_sel,
                           input logic [gbp_pkg::CFG_DATA_W-1:0] value);
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    cfg_pwrite  <= 1'b1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_instr(output logic [IN_W-1:0] word);
    int          r;
    int          i;
    logic [47:0] addr;
    logic [47:0] dest;
    logic [3:0]  len;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      i    = $urandom_range(0, HOT_COUNT - 1);
      addr = hot_pc[i];
      len  = hot_len[i];
      if ($urandom_range(0, 99) < hot_bias[i]) begin
        dest = ($urandom_range(0, 9) == 0) ? rand48() : hot_dest[i];
      end else begin
        dest = addr + {44'd0, len};
      end
      word = pack_instr(addr, len, dest, 1'b1, hot_cond[i]);
    end else if (r < 85) begin
      addr = rand48();
      len  = 4'($urandom_range(1, 15));
      dest = ($urandom_range(0, 3) == 0) ? rand48() : addr + {44'd0, len};
      word = pack_instr(addr, len, dest, 1'b0, 1'($urandom_range(0, 1)));
    end else begin
      word = pack_instr(rand48(), 4'($urandom_range(1, 15)), rand48(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [IN_W-1:0]               word;
    logic [47:0]                   tmp;
    logic [47:0]                   addr;
    logic [gbp_pkg::CBITS_W-1:0]   cbits_plan [5];
    logic [gbp_pkg::HMODE_W-1:0]   hmode_plan [5];
    bit                            tx_steady;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    cbits_plan  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    hmode_plan  = '{gbp_pkg::HASH_XOR, gbp_pkg::HASH_HIST, HASH_XOR_ALIAS,
                    gbp_pkg::HASH_PC, gbp_pkg::HASH_XOR};

    // hot branches: a crowded btb set, tag-zero ones, one near the top of memory
    for (int i = 0; i < HOT_COUNT; i++) begin
      tmp = rand48();
      if (i < 8) hot_pc[i] = {tmp[47:10], 8'h5A, tmp[1:0]};
      else if (i < 12) hot_pc[i] = {38'd0, tmp[9:0]};
      else if (i == 12) hot_pc[i] = 48'hFFFF_FFFF_FFF8;
      else hot_pc[i] = tmp;
      hot_len[i]  = 4'($urandom_range(1, 15));
      hot_dest[i] = ($urandom_range(0, 1) == 0) ? rand48() : hot_pc[i] - 48'd64;
      hot_cond[i] = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: hot_bias[i] = 5;
        1: hot_bias[i] = 95;
        2: hot_bias[i] = 50;
        default: hot_bias[i] = $urandom_range(0, 100);
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at reset settings
    send_instr(pack_instr(48'h1000, 4'd4, 48'h1004, 1'b0, 1'b0), idle_len());
    send_instr(pack_instr(48'h1000, 4'd4, 48'h2000, 1'b0, 1'b0), idle_len());
    send_instr(pack_instr(48'h0040, 4'd2, 48'h0080, 1'b1, 1'b0), idle_len());
    send_instr(pack_instr(48'h0044, 4'd4, 48'h0048, 1'b1, 1'b1), idle_len());
    send_instr(pack_instr(48'h0044, 4'd4, 48'h0010, 1'b1, 1'b1), idle_len());
    send_instr(pack_instr(ADDR_MASK, 4'd15, 48'h00E, 1'b1, 1'b1), idle_len());
    send_instr(pack_instr(ADDR_MASK, 4'd1, 48'h000, 1'b1, 1'b0), idle_len());
    send_instr(pack_instr(48'h0, 4'd1, ADDR_MASK, 1'b1, 1'b1), idle_len());
    send_instr(pack_instr(48'h3000, 4'd4, 48'h3004, 1'b0, 1'b1), idle_len());
    send_instr(pack_instr(48'h3000, 4'd8, ADDR_MASK, 1'b0, 1'b1), idle_len());
    // five tags into one four-way set, then the evicted and the kept one
    for (int t = 1; t <= 5; t++) begin
      addr = (48'(t) << 10) | (48'h33 << 2);
      send_instr(pack_instr(addr, 4'd4, rand48(), 1'b1, 1'b1), idle_len());
    end
    send_instr(pack_instr((48'd1 << 10) | (48'h33 << 2), 4'd4, 48'h5000, 1'b1, 1'b1),
               idle_len());
    send_instr(pack_instr((48'd5 << 10) | (48'h33 << 2), 4'd4, 48'h1418, 1'b1, 1'b1),
               idle_len());

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        in_tvalid <= 1'b0;
        wait_drained();
        write_reg(gbp_pkg::REG_HASH_MODE, {30'd0, hmode_plan[phase-1]});
        write_reg(gbp_pkg::REG_COUNTER_BITS, {28'd0, cbits_plan[phase-1]});
      end
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      for (int k = 0; k < 100; k++) begin
        if (phase == 1 && k == 1) hold_req = 1'b1;
        if (phase == 2 && k == 50) begin
          in_tvalid <= 1'b0;
          wait_drained();
        end
        random_instr(word);
        send_instr(word, (tx_steady || (phase == 1 && k < 60)) ? 0 : idle_len());
      end
    end
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
